@@ src/ittf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ittf_pkg
// Types, constants and character helpers shared by the integer formatter.
// ----------------------------------------------------------------------------
package ittf_pkg;

   // Default configuration of the core.
   localparam int ITTF_VALUE_BITS = 32;
   localparam int ITTF_MAX_WIDTH  = 63;

   // Width of every segment length and of the total text length.
   localparam int ITTF_LEN_W = 7;

   // Bit positions inside the flags field.
   localparam int FLAG_ZEROPAD = 0;
   localparam int FLAG_SIGNED  = 1;
   localparam int FLAG_PLUS    = 2;
   localparam int FLAG_SPACE   = 3;
   localparam int FLAG_LEFT    = 4;
   localparam int FLAG_LOWER   = 5;
   localparam int FLAG_PREFIX  = 6;

   // ASCII codes used by the formatter.
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_X     = 8'h58;
   localparam logic [7:0] CASE_BIT = 8'h20;

   // Bases that carry a radix prefix.
   localparam logic [4:0] BASE_OCT = 5'd8;
   localparam logic [4:0] BASE_HEX = 5'd16;

   // Digit characters, digit 0 in the low byte.
   localparam logic [127:0] DIGIT_SET = "FEDCBA9876543210";

   // One input item.
   typedef struct packed {
      logic [31:0] value;
      logic [4:0]  base;
      logic [5:0]  text_width;
      logic [5:0]  min_digits;
      logic [6:0]  flags;
   } req_type;

   // One character of result text.
   typedef struct packed {
      logic [7:0] char_out;
      logic       last;
      logic       bad_base;
   } rsp_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_SIZE,
      ST_EMIT,
      ST_ERROR
   } state_type;

   // Text segments in output order.
   typedef enum logic [2:0] {
      PH_LEAD,
      PH_SIGN,
      PH_PFX,
      PH_ZPAD,
      PH_PZERO,
      PH_DIGIT,
      PH_TRAIL
   } phase_type;

   // Digit value to ASCII; the case bit only affects the letters.
   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
      return DIGIT_SET[{d, 3'b000} +: 8] | (lower ? CASE_BIT : CH_NUL);
   endfunction

endpackage

@@ src/integer_to_text_formatter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_text_formatter_core
// Formats one integer as printf-style text, one ASCII character per result.
// ----------------------------------------------------------------------------
// Usage:
// An item is accepted at a clock edge where start is high and busy is low;
// req_data carries the value, base, field width, minimum digits and flags.
// busy stays high until the last character is loaded into the output register.
// Each character appears on rsp_data for one cycle with rsp_valid high, and
// rsp_data.last marks the final character. A base outside 2 to 16 gives one
// transfer with bad_base and last set and a zero character.
// Sequence: sign handling, then one pass of the shared bit-serial divider per
// digit (digits = length of the value in the base), length setup, then the
// characters with an idle step at each text segment boundary (at most six),
// and the output register. Base 2 is the worst case, as it gives the most
// digits; the divider loop dominates the total time.
// Reset clears the sequencer and the strobe; no item is in flight after it.
// The receiver cannot stall, so every character is taken as it appears.
// ----------------------------------------------------------------------------
module integer_to_text_formatter_core #(
   parameter int VALUE_BITS = ittf_pkg::ITTF_VALUE_BITS,
   parameter int MAX_WIDTH  = ittf_pkg::ITTF_MAX_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ittf_pkg::req_type req_data,
   output logic              rsp_valid,
   output ittf_pkg::rsp_type rsp_data
);
   import ittf_pkg::*;

   localparam int ND_W   = $clog2(VALUE_BITS + 1);
   localparam int IDX_W  = $clog2(VALUE_BITS);
   localparam int SENT_W = $clog2(MAX_WIDTH + 1);
   localparam int LW     = ITTF_LEN_W;

   state_type             state_ff, state_in;
   phase_type             phase_ff, phase_in;
   req_type               req_ff, req_in;
   logic [VALUE_BITS-1:0] mag;
   logic                  neg;
   logic [7:0]            sign_ch_ff, sign_ch_in;
   logic [ND_W-1:0]       nd_ff, nd_in;
   logic [3:0]            digits_ff [VALUE_BITS];
   logic                  dig_we;
   logic [LW-1:0]         cnt_ff, cnt_in;
   logic [SENT_W-1:0]     sent_ff, sent_in;
   logic [LW-1:0]         kept_ff, kept_in;
   logic [LW-1:0]         lead_ff, lead_in;
   logic [LW-1:0]         sign_len_ff, sign_len_in;
   logic [LW-1:0]         pfx_len_ff, pfx_len_in;
   logic [LW-1:0]         zpad_ff, zpad_in;
   logic [LW-1:0]         pzero_ff, pzero_in;
   logic [LW-1:0]         trail_ff, trail_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  div_start, div_done;
   logic [VALUE_BITS-1:0] div_dividend, div_quot;
   logic [3:0]            div_rem;

   logic                  left, zp_eff, lower;
   logic [LW-1:0]         nd_ext, md_ext, fw_ext, prec, overhead, pad, total;
   logic [LW-1:0]         dig_pos;
   logic [LW-1:0]         next_len;
   phase_type             next_phase;
   logic [7:0]            ch;

   // Shared divider used once per digit.
   ittf_div #(
      .VALUE_BITS(VALUE_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (req_ff.base),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // Flag decode, sign handling and segment lengths.
   always_comb begin
      left   = req_ff.flags[FLAG_LEFT];
      zp_eff = req_ff.flags[FLAG_ZEROPAD] & ~left;
      lower  = req_ff.flags[FLAG_LOWER];

      neg = req_ff.flags[FLAG_SIGNED] & req_ff.value[VALUE_BITS-1];
      mag = neg ? (~req_ff.value[VALUE_BITS-1:0] + 1'b1) : req_ff.value[VALUE_BITS-1:0];

      nd_ext   = LW'(nd_ff);
      md_ext   = LW'(req_ff.min_digits);
      fw_ext   = LW'(req_ff.text_width);
      prec     = (nd_ext > md_ext) ? nd_ext : md_ext;
      pfx_len_in = LW'(0);
      if (req_ff.flags[FLAG_PREFIX]) begin
         if (req_ff.base == BASE_HEX) begin
            pfx_len_in = LW'(2);
         end else if (req_ff.base == BASE_OCT) begin
            pfx_len_in = LW'(1);
         end
      end
      sign_len_in = (sign_ch_ff != CH_NUL) ? LW'(1) : LW'(0);
      overhead    = prec + sign_len_in + pfx_len_in;
      pad         = (fw_ext > overhead) ? (fw_ext - overhead) : LW'(0);
      total       = pad + overhead;
      pzero_in    = prec - nd_ext;
      lead_in     = (!zp_eff && !left) ? pad : LW'(0);
      zpad_in     = zp_eff ? pad : LW'(0);
      trail_in    = left ? pad : LW'(0);
      kept_in     = (total > LW'(MAX_WIDTH)) ? LW'(MAX_WIDTH) : total;
   end

   // Segment following the current one and its length.
   always_comb begin
      case (phase_ff)
         PH_LEAD:  next_phase = PH_SIGN;
         PH_SIGN:  next_phase = PH_PFX;
         PH_PFX:   next_phase = PH_ZPAD;
         PH_ZPAD:  next_phase = PH_PZERO;
         PH_PZERO: next_phase = PH_DIGIT;
         default:  next_phase = PH_TRAIL;
      endcase
      case (next_phase)
         PH_SIGN:  next_len = sign_len_ff;
         PH_PFX:   next_len = pfx_len_ff;
         PH_ZPAD:  next_len = zpad_ff;
         PH_PZERO: next_len = pzero_ff;
         PH_DIGIT: next_len = LW'(nd_ff);
         PH_TRAIL: next_len = trail_ff;
         default:  next_len = lead_ff;
      endcase
   end

   // Character of the current segment.
   always_comb begin
      dig_pos = cnt_ff - 1'b1;
      case (phase_ff)
         PH_SIGN:  ch = sign_ch_ff;
         PH_PFX:   ch = (cnt_ff == LW'(1) && req_ff.base == BASE_HEX) ?
                        (CH_X | (lower ? CASE_BIT : CH_NUL)) : CH_ZERO;
         PH_ZPAD:  ch = CH_ZERO;
         PH_PZERO: ch = CH_ZERO;
         PH_DIGIT: ch = digit_char(digits_ff[dig_pos[IDX_W-1:0]], lower);
         default:  ch = CH_SPACE;
      endcase
   end

   // Sequencer: sign, digit loop, sizing, then character emission; a bad base gives an error transfer.
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      req_in       = req_ff;
      sign_ch_in   = sign_ch_ff;
      nd_in        = nd_ff;
      cnt_in       = cnt_ff;
      sent_in      = sent_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      div_start    = 1'b0;
      div_dividend = mag;
      dig_we       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = (req_data.base inside {[5'd2:5'd16]}) ? ST_CHECK : ST_ERROR;
            end
         end
         ST_CHECK: begin
            if (neg) begin
               sign_ch_in = CH_MINUS;
            end else if (req_ff.flags[FLAG_SIGNED] && req_ff.flags[FLAG_PLUS]) begin
               sign_ch_in = CH_PLUS;
            end else if (req_ff.flags[FLAG_SIGNED] && req_ff.flags[FLAG_SPACE]) begin
               sign_ch_in = CH_SPACE;
            end else begin
               sign_ch_in = CH_NUL;
            end
            nd_in     = '0;
            div_start = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            div_dividend = div_quot;
            if (div_done) begin
               dig_we = 1'b1;
               nd_in  = nd_ff + 1'b1;
               if (div_quot == '0) begin
                  state_in = ST_SIZE;
               end else begin
                  div_start = 1'b1;
               end
            end
         end
         ST_SIZE: begin
            phase_in = PH_LEAD;
            cnt_in   = lead_in;
            sent_in  = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (cnt_ff == '0) begin
               phase_in = next_phase;
               cnt_in   = next_len;
            end else begin
               cnt_in          = cnt_ff - 1'b1;
               sent_in         = sent_ff + 1'b1;
               rsp_valid_in    = 1'b1;
               rsp_in.char_out = ch;
               rsp_in.bad_base = 1'b0;
               rsp_in.last     = (LW'(sent_ff) + 1'b1) == kept_ff;
               if (rsp_in.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ERROR: begin
            rsp_valid_in    = 1'b1;
            rsp_in.char_out = CH_NUL;
            rsp_in.last     = 1'b1;
            rsp_in.bad_base = 1'b1;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and strobe registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      phase_ff   <= phase_in;
      req_ff     <= req_in;
      sign_ch_ff <= sign_ch_in;
      nd_ff      <= nd_in;
      cnt_ff     <= cnt_in;
      sent_ff    <= sent_in;
      rsp_ff     <= rsp_in;
      if (state_ff == ST_SIZE) begin
         kept_ff     <= kept_in;
         lead_ff     <= lead_in;
         sign_len_ff <= sign_len_in;
         pfx_len_ff  <= pfx_len_in;
         zpad_ff     <= zpad_in;
         pzero_ff    <= pzero_in;
         trail_ff    <= trail_in;
      end
   end

   // Digit store, least significant digit first.
   always_ff @(posedge clock) begin
      if (dig_we) begin
         digits_ff[nd_ff[IDX_W-1:0]] <= div_rem;
      end
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ src/ittf_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ittf_div
// Restoring divider by a small base, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ittf_div #(
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] dividend,
   input  logic [4:0]            divisor,
   output logic                  done,
   output logic [VALUE_BITS-1:0] quotient,
   output logic [3:0]            remainder
);
   localparam int CNT_W = $clog2(VALUE_BITS + 1);

   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] quo_ff, quo_in;
   logic [3:0]            rem_ff, rem_in;
   logic [4:0]            trial;
   logic                  fits;

   // One shift and trial subtract per cycle.
   always_comb begin
      trial   = {rem_ff, quo_ff[VALUE_BITS-1]};
      fits    = trial >= divisor;
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CNT_W'(VALUE_BITS);
         quo_in = dividend;
         rem_in = 4'd0;
      end else if (run_ff) begin
         quo_in = {quo_ff[VALUE_BITS-2:0], fits};
         rem_in = fits ? 4'(trial - divisor) : trial[3:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
